// File: sv/msgtok_pkg.sv
// Shared types, codes and helpers for the MessagePack stream tokenizer.
// Used by msgtok_decode and msgpack_stream_tokenizer_unit; no dependencies.
`default_nettype none
package msgtok_pkg;

    localparam int unsigned DEF_MAX_DEPTH = 16;

    // Type bytes with a special meaning.
    localparam logic [7:0] B_NIL       = 8'hC0;
    localparam logic [7:0] B_FALSE     = 8'hC2;
    localparam logic [7:0] B_TRUE      = 8'hC3;
    localparam logic [7:0] B_FIXINT_LO = 8'h80;
    localparam logic [7:0] B_NEGFIX_LO = 8'hE0;
    localparam logic [7:0] B_FIXSTR    = 8'hA0;
    localparam logic [7:0] B_FIXARR    = 8'h90;
    localparam logic [7:0] B_FIXMAP    = 8'h80;
    localparam logic [7:0] M_TOP3      = 8'hE0;
    localparam logic [7:0] M_TOP4      = 8'hF0;
    localparam logic [7:0] M_LOW5      = 8'h1F;
    localparam logic [7:0] M_LOW4      = 8'h0F;

    // Token kinds.
    localparam logic [3:0] K_NIL     = 4'd0;
    localparam logic [3:0] K_FALSE   = 4'd1;
    localparam logic [3:0] K_TRUE    = 4'd2;
    localparam logic [3:0] K_UINT    = 4'd3;
    localparam logic [3:0] K_INT     = 4'd4;
    localparam logic [3:0] K_F64     = 4'd5;
    localparam logic [3:0] K_STR     = 4'd6;
    localparam logic [3:0] K_BIN     = 4'd7;
    localparam logic [3:0] K_ARRAY   = 4'd8;
    localparam logic [3:0] K_MAP     = 4'd9;
    localparam logic [3:0] K_PAYLOAD = 4'd10;
    localparam logic [3:0] K_ERROR   = 4'd11;

    // Error codes.
    localparam logic [1:0] E_NONE      = 2'd0;
    localparam logic [1:0] E_BAD_TYPE  = 2'd1;
    localparam logic [1:0] E_TRUNCATED = 2'd2;
    localparam logic [1:0] E_TOO_DEEP  = 2'd3;

    // What a decoded byte asks the control logic to do.
    typedef enum logic [2:0] {
        CL_NONE = 3'd0,  // no token yet
        CL_HDR  = 3'd1,  // multi-byte header starts
        CL_FIN  = 3'd2,  // complete value, count it against its parent
        CL_TOK  = 3'd3,  // token without completing a value
        CL_STR  = 3'd4,  // str/bin header with length
        CL_CONT = 3'd5,  // array/map header with count
        CL_ERR1 = 3'd6   // rejected type byte
    } t_cls;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic [4:0]  nest_depth;
        logic        object_end;
        logic [1:0]  error_code;
    } t_out;

    typedef struct packed {
        t_cls        cls;
        logic [3:0]  kind;
        logic [63:0] value;
        logic [3:0]  hdr_len;
    } t_dec;

    // Number of big-endian header bytes after a type byte, 0 if none.
    function automatic logic [3:0] hdr_bytes(input logic [7:0] t);
        logic [3:0] n;
        n = 4'd0;
        case (t)
            8'hCC, 8'hD0, 8'hD9, 8'hC4:               n = 4'd1;
            8'hCD, 8'hD1, 8'hDA, 8'hC5, 8'hDC, 8'hDE: n = 4'd2;
            8'hCE, 8'hD2, 8'hDB, 8'hC6, 8'hDD, 8'hDF: n = 4'd4;
            8'hCF, 8'hD3, 8'hCB:                      n = 4'd8;
            default:                                  n = 4'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// File: sv/msgpack_stream_tokenizer_unit.sv
// Top level of the MessagePack stream tokenizer: control, stack memory, APB register.
// Depends on msgtok_pkg and msgtok_decode.
`default_nettype none
// One byte item is taken per accept; a byte that produces no token or a token that
// does not complete a value is handled without leaving the idle state. A byte that
// completes a value walks the open-container stack in a memory with a registered read
// port, reading (S_RD) and then evaluating (S_EV) each level it looks at, until an
// enclosing container stays open or the stack empties. The input stalls while that walk
// runs and while an undelivered result sits in the output register.
// Register 0 (byte address 0) is depth_limit; 0 acts as 1 and values above MAX_DEPTH
// act as MAX_DEPTH. Stack entries need no clearing after reset.
module msgpack_stream_tokenizer_unit #(
    parameter int unsigned MAX_DEPTH = msgtok_pkg::DEF_MAX_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire msgtok_pkg::t_in   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output msgtok_pkg::t_out       o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned TW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EV   = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HDR  = 3'b010,
        PH_PAY  = 3'b100
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [3:0]       r_pend, n_pend;
    logic [63:0]      r_acc, n_acc;
    logic [31:0]      r_left, n_left;
    logic [TW-1:0]    r_top, n_top;
    logic             r_hold, n_hold;
    logic [4:0]       r_lim;
    logic [3:0]       r_tkind, n_tkind;
    logic [63:0]      r_tval, n_tval;
    logic [4:0]       r_depth, n_depth;
    logic             r_eob, n_eob;
    logic             r_out_valid;
    msgtok_pkg::t_out r_out, n_out;
    logic             emit;

    logic [32:0]      r_mem [MAX_DEPTH];
    logic [32:0]      r_rdata;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [32:0]      mem_wd;

    logic             accept, cfg_wr, hdr_done;
    logic [63:0]      acc_sh;
    logic [3:0]       pend_dec;
    logic [TW-1:0]    top_m1;
    int unsigned      lim_eff;
    msgtok_pkg::t_dec dec;

    assign accept   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
    assign pready   = 1'b1;
    assign prdata   = {27'd0, r_lim};
    assign acc_sh   = {r_acc[55:0], i_in_data.data_byte};
    assign pend_dec = (r_pend != 4'd0) ? (r_pend - 4'd1) : 4'd0;
    assign hdr_done = (r_phase == PH_HDR) && (pend_dec == 4'd0);
    assign top_m1   = r_top - TW'(1);

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        lim_eff = (r_lim == 5'd0) ? 1 : 32'(r_lim);
        if (lim_eff > MAX_DEPTH) begin
            lim_eff = MAX_DEPTH;
        end
    end

    msgtok_decode u_decode (
        .i_hdr_done (hdr_done),
        .i_byte     (i_in_data.data_byte),
        .i_type     (r_type),
        .i_acc      (acc_sh),
        .o_dec      (dec)
    );

    always_comb begin
        msgtok_pkg::t_cls cls;
        logic             eob;
        logic [3:0]       kind;
        logic [63:0]      val;
        logic [1:0]       err;

        n_state = r_state;
        n_phase = r_phase;
        n_type  = r_type;
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_left  = r_left;
        n_top   = r_top;
        n_hold  = r_hold;
        n_tkind = r_tkind;
        n_tval  = r_tval;
        n_depth = r_depth;
        n_eob   = r_eob;
        n_out   = r_out;
        emit    = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = r_top[AW-1:0];
        mem_wd  = r_rdata - 33'd1;
        mem_re  = 1'b0;
        mem_ra  = top_m1[AW-1:0];
        cls     = msgtok_pkg::CL_NONE;
        eob     = i_in_data.end_of_buffer;
        kind    = dec.kind;
        val     = dec.value;
        err     = msgtok_pkg::E_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (accept && r_hold) begin
                    if (eob) begin
                        n_hold = 1'b0;
                    end
                end else if (accept) begin
                    unique case (r_phase)
                        PH_HDR: begin
                            n_acc  = acc_sh;
                            n_pend = pend_dec;
                            if (hdr_done) begin
                                n_phase = PH_IDLE;
                                cls     = dec.cls;
                            end
                        end
                        PH_PAY: begin
                            kind   = msgtok_pkg::K_PAYLOAD;
                            val    = {56'd0, i_in_data.data_byte};
                            n_left = (r_left != 32'd0) ? (r_left - 32'd1) : 32'd0;
                            if (n_left == 32'd0) begin
                                n_phase = PH_IDLE;
                                cls     = msgtok_pkg::CL_FIN;
                            end else begin
                                cls = msgtok_pkg::CL_TOK;
                            end
                        end
                        default: begin
                            cls = dec.cls;
                            if (dec.cls == msgtok_pkg::CL_HDR) begin
                                n_type  = i_in_data.data_byte;
                                n_pend  = dec.hdr_len;
                                n_acc   = 64'd0;
                                n_phase = PH_HDR;
                                cls     = msgtok_pkg::CL_NONE;
                            end
                        end
                    endcase

                    // Open strings and containers resolve to a completed value, a plain token, a push or a depth error.
                    if (cls == msgtok_pkg::CL_STR) begin
                        if (val[31:0] == 32'd0) begin
                            cls = msgtok_pkg::CL_FIN;
                        end else begin
                            cls     = msgtok_pkg::CL_TOK;
                            n_phase = PH_PAY;
                            n_left  = val[31:0];
                        end
                    end else if (cls == msgtok_pkg::CL_CONT) begin
                        if (val[31:0] == 32'd0) begin
                            cls = msgtok_pkg::CL_FIN;
                        end else if (32'(r_top) >= lim_eff) begin
                            err = msgtok_pkg::E_TOO_DEEP;
                        end else begin
                            cls    = msgtok_pkg::CL_TOK;
                            mem_we = 1'b1;
                            mem_wd = (kind == msgtok_pkg::K_MAP) ?
                                     {val[31:0], 1'b0} : {1'b0, val[31:0]};
                            n_top  = r_top + TW'(1);
                        end
                    end else if (cls == msgtok_pkg::CL_ERR1) begin
                        err = msgtok_pkg::E_BAD_TYPE;
                    end

                    if (err == msgtok_pkg::E_NONE && cls == msgtok_pkg::CL_FIN) begin
                        n_tkind = kind;
                        n_tval  = val;
                        n_depth = 5'(r_top);
                        n_eob   = eob;
                        n_state = S_RD;
                    end else begin
                        if (err == msgtok_pkg::E_NONE && eob &&
                            (n_phase != PH_IDLE || n_top != '0)) begin
                            err = msgtok_pkg::E_TRUNCATED;
                        end
                        if (err != msgtok_pkg::E_NONE) begin
                            emit  = 1'b1;
                            n_out = '{msgtok_pkg::K_ERROR, 64'd0, 5'(r_top), 1'b0, err};
                            n_phase = PH_IDLE;
                            n_pend  = 4'd0;
                            n_acc   = 64'd0;
                            n_left  = 32'd0;
                            n_top   = '0;
                            n_hold  = !eob;
                            mem_we  = 1'b0;
                        end else if (cls == msgtok_pkg::CL_TOK) begin
                            emit  = 1'b1;
                            n_out = '{kind, val, 5'(r_top), 1'b0, msgtok_pkg::E_NONE};
                        end
                    end
                end
            end
            S_RD: begin
                if (r_top == '0) begin
                    emit    = 1'b1;
                    n_out   = '{r_tkind, r_tval, r_depth, 1'b1, msgtok_pkg::E_NONE};
                    n_state = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_EV;
                end
            end
            S_EV: begin
                if (r_rdata > 33'd1) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_eob) begin
                        // The enclosing container is still open at end of buffer.
                        n_out  = '{msgtok_pkg::K_ERROR, 64'd0, r_depth, 1'b0,
                                   msgtok_pkg::E_TRUNCATED};
                        n_phase = PH_IDLE;
                        n_pend  = 4'd0;
                        n_acc   = 64'd0;
                        n_left  = 32'd0;
                        n_top   = '0;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = top_m1[AW-1:0];
                        n_out  = '{r_tkind, r_tval, r_depth, 1'b0, msgtok_pkg::E_NONE};
                    end
                end else begin
                    n_top   = top_m1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_type      <= 8'd0;
            r_pend      <= 4'd0;
            r_acc       <= 64'd0;
            r_left      <= 32'd0;
            r_top       <= '0;
            r_hold      <= 1'b0;
            r_lim       <= 5'd16;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_type  <= n_type;
            r_pend  <= n_pend;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_top   <= n_top;
            r_hold  <= n_hold;
            if (cfg_wr) begin
                r_lim <= pwdata[4:0];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tkind <= n_tkind;
        r_tval  <= n_tval;
        r_depth <= n_depth;
        r_eob   <= n_eob;
        r_out   <= n_out;
    end

    a_walk_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("stack walk running while a result is still pending");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) <= MAX_DEPTH)
        else $error("stack top beyond MAX_DEPTH");

    a_hold_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> (r_top == '0 && r_phase == PH_IDLE))
        else $error("drop mode with parser state left open");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.token_kind != msgtok_pkg::K_ERROR)
        |-> (o_out_data.error_code == msgtok_pkg::E_NONE))
        else $error("error code on a non-error token");

endmodule
`default_nettype wire

// File: sv/msgtok_decode.sv
// Classifies a type byte, or a completed multi-byte header, into a token.
// Depends on msgtok_pkg.
`default_nettype none
module msgtok_decode (
    input  wire logic                i_hdr_done,
    input  wire logic [7:0]          i_byte,
    input  wire logic [7:0]          i_type,
    input  wire logic [63:0]         i_acc,
    output msgtok_pkg::t_dec         o_dec
);

    always_comb begin
        o_dec.cls     = msgtok_pkg::CL_FIN;
        o_dec.kind    = msgtok_pkg::K_NIL;
        o_dec.value   = 64'd0;
        o_dec.hdr_len = 4'd0;
        if (i_hdr_done) begin
            unique case (i_type)
                8'hCC, 8'hCD, 8'hCE, 8'hCF: begin
                    o_dec.kind  = msgtok_pkg::K_UINT;
                    o_dec.value = i_acc;
                end
                8'hD0: begin
                    o_dec.kind  = msgtok_pkg::K_INT;
                    o_dec.value = {{56{i_acc[7]}}, i_acc[7:0]};
                end
                8'hD1: begin
                    o_dec.kind  = msgtok_pkg::K_INT;
                    o_dec.value = {{48{i_acc[15]}}, i_acc[15:0]};
                end
                8'hD2: begin
                    o_dec.kind  = msgtok_pkg::K_INT;
                    o_dec.value = {{32{i_acc[31]}}, i_acc[31:0]};
                end
                8'hD3: begin
                    o_dec.kind  = msgtok_pkg::K_INT;
                    o_dec.value = i_acc;
                end
                8'hCB: begin
                    o_dec.kind  = msgtok_pkg::K_F64;
                    o_dec.value = i_acc;
                end
                8'hD9, 8'hDA, 8'hDB: begin
                    o_dec.cls   = msgtok_pkg::CL_STR;
                    o_dec.kind  = msgtok_pkg::K_STR;
                    o_dec.value = {32'd0, i_acc[31:0]};
                end
                8'hC4, 8'hC5, 8'hC6: begin
                    o_dec.cls   = msgtok_pkg::CL_STR;
                    o_dec.kind  = msgtok_pkg::K_BIN;
                    o_dec.value = {32'd0, i_acc[31:0]};
                end
                8'hDC, 8'hDD: begin
                    o_dec.cls   = msgtok_pkg::CL_CONT;
                    o_dec.kind  = msgtok_pkg::K_ARRAY;
                    o_dec.value = {32'd0, i_acc[31:0]};
                end
                default: begin
                    o_dec.cls   = msgtok_pkg::CL_CONT;
                    o_dec.kind  = msgtok_pkg::K_MAP;
                    o_dec.value = {32'd0, i_acc[31:0]};
                end
            endcase
        end else if (i_byte < msgtok_pkg::B_FIXINT_LO) begin
            o_dec.kind  = msgtok_pkg::K_UINT;
            o_dec.value = {56'd0, i_byte};
        end else if (i_byte >= msgtok_pkg::B_NEGFIX_LO) begin
            o_dec.kind  = msgtok_pkg::K_INT;
            o_dec.value = {{56{1'b1}}, i_byte};
        end else if ((i_byte & msgtok_pkg::M_TOP3) == msgtok_pkg::B_FIXSTR) begin
            o_dec.cls   = msgtok_pkg::CL_STR;
            o_dec.kind  = msgtok_pkg::K_STR;
            o_dec.value = {56'd0, i_byte & msgtok_pkg::M_LOW5};
        end else if ((i_byte & msgtok_pkg::M_TOP4) == msgtok_pkg::B_FIXARR) begin
            o_dec.cls   = msgtok_pkg::CL_CONT;
            o_dec.kind  = msgtok_pkg::K_ARRAY;
            o_dec.value = {56'd0, i_byte & msgtok_pkg::M_LOW4};
        end else if ((i_byte & msgtok_pkg::M_TOP4) == msgtok_pkg::B_FIXMAP) begin
            o_dec.cls   = msgtok_pkg::CL_CONT;
            o_dec.kind  = msgtok_pkg::K_MAP;
            o_dec.value = {56'd0, i_byte & msgtok_pkg::M_LOW4};
        end else if (i_byte == msgtok_pkg::B_NIL) begin
            o_dec.kind = msgtok_pkg::K_NIL;
        end else if (i_byte == msgtok_pkg::B_FALSE) begin
            o_dec.kind = msgtok_pkg::K_FALSE;
        end else if (i_byte == msgtok_pkg::B_TRUE) begin
            o_dec.kind = msgtok_pkg::K_TRUE;
        end else if (msgtok_pkg::hdr_bytes(i_byte) == 4'd0) begin
            o_dec.cls = msgtok_pkg::CL_ERR1;
        end else begin
            o_dec.cls     = msgtok_pkg::CL_HDR;
            o_dec.hdr_len = msgtok_pkg::hdr_bytes(i_byte);
        end
    end

endmodule
`default_nettype wire

// File: dv/tb_msgpack_stream_tokenizer_unit.sv
// Self-checking testbench for msgpack_stream_tokenizer_unit: a queue-fed byte driver,
// a token predictor and a token monitor. Depends on msgtok_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_msgpack_stream_tokenizer_unit;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned DRAIN_WAIT = 2 * STACK_DEPTH + 20;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned LONG_HOLD = 400;
    localparam logic [2:0] ADDR_DEPTH_LIMIT = 3'd0;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD} t_phase;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    msgtok_pkg::t_in i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    msgtok_pkg::t_out o_out_data;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    msgpack_stream_tokenizer_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    msgtok_pkg::t_in byte_q[$];
    msgtok_pkg::t_out token_q[$];
    int unsigned err_count = 0;
    bit quiet = 0;
    bit hold_req = 0;

    // Tokenizer state as predicted from the accepted bytes.
    logic [4:0] depth_limit_reg = 5'd16;
    t_phase phase = PH_IDLE;
    logic [7:0] type_reg = '0;
    int unsigned hdr_left = 0;
    logic [63:0] field_acc = '0;
    logic [31:0] payload_cnt = '0;
    logic [32:0] kids[STACK_DEPTH];
    int unsigned sp = 0;
    bit drop_to_eob = 0;

    bit tk_have;
    logic [3:0] tk_kind;
    logic [63:0] tk_val;
    bit tk_end;
    logic [1:0] tk_err;

    function automatic int unsigned header_len(input logic [7:0] t);
        case (t)
            8'hCC, 8'hD0, 8'hD9, 8'hC4: return 1;
            8'hCD, 8'hD1, 8'hDA, 8'hC5, 8'hDC, 8'hDE: return 2;
            8'hCE, 8'hD2, 8'hDB, 8'hC6, 8'hDD, 8'hDF: return 4;
            8'hCF, 8'hD3, 8'hCB: return 8;
            default: return 0;
        endcase
    endfunction

    // Counts a completed value against its parents; 1 when a top-level value closes.
    function automatic bit close_value();
        while (sp > 0) begin
            if (kids[sp-1] > 1) begin
                kids[sp-1] = kids[sp-1] - 1;
                return 0;
            end
            kids[sp-1] = '0;
            sp = sp - 1;
        end
        return 1;
    endfunction

    function automatic void emit_value(input logic [3:0] kind, input logic [63:0] v);
        tk_have = 1;
        tk_kind = kind;
        tk_val = v;
        tk_end = close_value();
    endfunction

    function automatic void open_string(input logic [3:0] kind, input logic [31:0] len);
        tk_have = 1;
        tk_kind = kind;
        tk_val = {32'd0, len};
        if (len == 0) begin
            tk_end = close_value();
        end else begin
            payload_cnt = len;
            phase = PH_PAYLOAD;
        end
    endfunction

    function automatic void open_container(input logic [3:0] kind, input logic [31:0] cnt);
        int unsigned lim;
        lim = (depth_limit_reg == 0) ? 1 : depth_limit_reg;
        if (lim > STACK_DEPTH) lim = STACK_DEPTH;
        if (cnt == 0) begin
            emit_value(kind, '0);
        end else if (sp >= lim) begin
            tk_err = msgtok_pkg::E_TOO_DEEP;
        end else begin
            kids[sp] = (kind == msgtok_pkg::K_MAP) ? {cnt, 1'b0} : {1'b0, cnt};
            sp = sp + 1;
            tk_have = 1;
            tk_kind = kind;
            tk_val = {32'd0, cnt};
        end
    endfunction

    function automatic void decode_header();
        logic [63:0] a;
        int unsigned nbits;
        a = field_acc;
        if (type_reg >= 8'hCC && type_reg <= 8'hCF) begin
            emit_value(msgtok_pkg::K_UINT, a);
        end else if (type_reg >= 8'hD0 && type_reg <= 8'hD3) begin
            nbits = 8 * header_len(type_reg);
            if (nbits < 64 && a[nbits-1]) a = a | (~64'd0 << nbits);
            emit_value(msgtok_pkg::K_INT, a);
        end else if (type_reg == 8'hCB) begin
            emit_value(msgtok_pkg::K_F64, a);
        end else if (type_reg >= 8'hD9 && type_reg <= 8'hDB) begin
            open_string(msgtok_pkg::K_STR, a[31:0]);
        end else if (type_reg >= 8'hC4 && type_reg <= 8'hC6) begin
            open_string(msgtok_pkg::K_BIN, a[31:0]);
        end else if (type_reg == 8'hDC || type_reg == 8'hDD) begin
            open_container(msgtok_pkg::K_ARRAY, a[31:0]);
        end else begin
            open_container(msgtok_pkg::K_MAP, a[31:0]);
        end
    endfunction

    function automatic void decode_type(input logic [7:0] b);
        if (b < 8'h80) begin
            emit_value(msgtok_pkg::K_UINT, {56'd0, b});
        end else if (b >= msgtok_pkg::B_NEGFIX_LO) begin
            emit_value(msgtok_pkg::K_INT, {56'hFF_FFFF_FFFF_FFFF, b});
        end else if ((b & msgtok_pkg::M_TOP3) == msgtok_pkg::B_FIXSTR) begin
            open_string(msgtok_pkg::K_STR, {27'd0, b[4:0]});
        end else if ((b & msgtok_pkg::M_TOP4) == msgtok_pkg::B_FIXARR) begin
            open_container(msgtok_pkg::K_ARRAY, {28'd0, b[3:0]});
        end else if ((b & msgtok_pkg::M_TOP4) == msgtok_pkg::B_FIXMAP) begin
            open_container(msgtok_pkg::K_MAP, {28'd0, b[3:0]});
        end else if (b == msgtok_pkg::B_NIL) begin
            emit_value(msgtok_pkg::K_NIL, '0);
        end else if (b == msgtok_pkg::B_FALSE) begin
            emit_value(msgtok_pkg::K_FALSE, '0);
        end else if (b == msgtok_pkg::B_TRUE) begin
            emit_value(msgtok_pkg::K_TRUE, '0);
        end else if (header_len(b) == 0) begin
            tk_err = msgtok_pkg::E_BAD_TYPE;
        end else begin
            type_reg = b;
            hdr_left = header_len(b);
            field_acc = '0;
            phase = PH_HEADER;
        end
    endfunction

    // Advances the predicted tokenizer by one byte; returns 1 when a token is due.
    function automatic bit predict_token(input msgtok_pkg::t_in it,
                                         output msgtok_pkg::t_out tok);
        logic [4:0] depth;
        depth = sp[4:0];
        tok = '0;
        if (drop_to_eob) begin
            if (it.end_of_buffer) drop_to_eob = 0;
            return 0;
        end
        tk_have = 0;
        tk_kind = msgtok_pkg::K_NIL;
        tk_val = '0;
        tk_end = 0;
        tk_err = msgtok_pkg::E_NONE;
        if (phase == PH_HEADER) begin
            field_acc = {field_acc[55:0], it.data_byte};
            if (hdr_left > 0) hdr_left = hdr_left - 1;
            if (hdr_left == 0) begin
                phase = PH_IDLE;
                decode_header();
            end
        end else if (phase == PH_PAYLOAD) begin
            tk_have = 1;
            tk_kind = msgtok_pkg::K_PAYLOAD;
            tk_val = {56'd0, it.data_byte};
            if (payload_cnt > 0) payload_cnt = payload_cnt - 1;
            if (payload_cnt == 0) begin
                phase = PH_IDLE;
                tk_end = close_value();
            end
        end else begin
            decode_type(it.data_byte);
        end
        if (tk_err == msgtok_pkg::E_NONE && it.end_of_buffer && (phase != PH_IDLE || sp != 0))
            tk_err = msgtok_pkg::E_TRUNCATED;
        if (tk_err != msgtok_pkg::E_NONE) begin
            tok.token_kind = msgtok_pkg::K_ERROR;
            tok.nest_depth = depth;
            tok.error_code = tk_err;
            phase = PH_IDLE;
            hdr_left = 0;
            field_acc = '0;
            payload_cnt = '0;
            sp = 0;
            drop_to_eob = !it.end_of_buffer;
            return 1;
        end
        if (!tk_have) return 0;
        tok.token_kind = tk_kind;
        tok.token_value = tk_val;
        tok.nest_depth = depth;
        tok.object_end = tk_end;
        return 1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Byte driver.
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                i_in_data <= byte_q.pop_front();
                i_in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Token receiver back-pressure, with one long hold-off on request.
    int unsigned stall_gap = 0;
    int unsigned hold_cnt = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_gap <= pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // Prediction on every accepted byte.
    always @(posedge i_clk) begin
        msgtok_pkg::t_out tok;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (predict_token(i_in_data, tok)) token_q.push_back(tok);
        end
    end

    // Token checker.
    always @(posedge i_clk) begin
        msgtok_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected token: kind %0d value %h", o_out_data.token_kind,
                             o_out_data.token_value);
            end else begin
                want = token_q.pop_front();
                if (o_out_data.token_kind !== want.token_kind
                        || o_out_data.token_value !== want.token_value
                        || o_out_data.nest_depth !== want.nest_depth
                        || o_out_data.object_end !== want.object_end
                        || o_out_data.error_code !== want.error_code) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"token mismatch: exp k%0d v%h d%0d e%0d c%0d, ",
                                  "got k%0d v%h d%0d e%0d c%0d"},
                                 want.token_kind, want.token_value, want.nest_depth,
                                 want.object_end, want.error_code,
                                 o_out_data.token_kind, o_out_data.token_value,
                                 o_out_data.nest_depth, o_out_data.object_end,
                                 o_out_data.error_code);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    int unsigned idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_byte(input logic [7:0] b, input bit eob = 0);
        msgtok_pkg::t_in it;
        it.data_byte = b;
        it.end_of_buffer = eob;
        byte_q.push_back(it);
    endtask

    task automatic add_be(ref logic [7:0] obj[$], input logic [63:0] v, input int unsigned n);
        for (int i = n - 1; i >= 0; i--) obj.push_back(v[8*i +: 8]);
    endtask

    // Appends one well-formed random value; deep_cap > lvl forces a nesting chain.
    task automatic gen_value(ref logic [7:0] obj[$], input int unsigned lvl,
                             input int unsigned deep_cap);
        int unsigned sel, n, cnt;
        logic [7:0] t;
        if (deep_cap > lvl) begin
            obj.push_back(8'h91);
            gen_value(obj, lvl + 1, deep_cap);
            return;
        end
        sel = $urandom_range(0, 12);
        if (lvl >= 4 && sel >= 9) sel = $urandom_range(0, 8);
        cnt = (lvl >= 2) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        case (sel)
            0: obj.push_back(8'($urandom_range(0, 8'h7F)));
            1: obj.push_back(8'($urandom_range(8'hE0, 8'hFF)));
            2: obj.push_back($urandom_range(0, 2) == 0 ? msgtok_pkg::B_NIL :
                             ($urandom_range(0, 1) ? msgtok_pkg::B_TRUE
                                                   : msgtok_pkg::B_FALSE));
            3, 4, 5: begin
                t = (sel == 5) ? 8'hCB
                               : 8'(((sel == 3) ? 8'hCC : 8'hD0) + $urandom_range(0, 3));
                obj.push_back(t);
                add_be(obj, {$urandom, $urandom}, header_len(t));
            end
            6, 7: begin
                n = $urandom_range(0, 4);
                if (sel == 6) begin
                    obj.push_back(msgtok_pkg::B_FIXSTR | 8'(n));
                end else begin
                    t = 8'(($urandom_range(0, 1) ? 8'hD9 : 8'hC4) + $urandom_range(0, 2));
                    obj.push_back(t);
                    add_be(obj, 64'(n), header_len(t));
                end
                repeat (n) obj.push_back(8'($urandom));
            end
            8: begin
                t = 8'(8'hDC + $urandom_range(0, 3));
                obj.push_back(t);
                add_be(obj, 64'(cnt), header_len(t));
                repeat (t >= 8'hDE ? 2 * cnt : cnt) gen_value(obj, lvl + 1, 0);
            end
            9, 10: begin
                obj.push_back(msgtok_pkg::B_FIXARR | 8'(cnt));
                repeat (cnt) gen_value(obj, lvl + 1, 0);
            end
            default: begin
                obj.push_back(msgtok_pkg::B_FIXMAP | 8'(cnt));
                repeat (2 * cnt) gen_value(obj, lvl + 1, 0);
            end
        endcase
    endtask

    // Random objects, one per buffer, with some truncated buffers and noise.
    task automatic gen_phase(input int unsigned n_bytes);
        logic [7:0] obj[$];
        int unsigned r, cut, lim;
        lim = (depth_limit_reg == 0) ? 1 : depth_limit_reg;
        if (lim > STACK_DEPTH) lim = STACK_DEPTH;
        while (n_bytes > 0) begin
            obj.delete();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 4)) obj.push_back(8'($urandom));
            end else begin
                gen_value(obj, 0, (r < 18) ? lim + $urandom_range(0, 1) : 0);
            end
            cut = obj.size();
            if (r >= 8 && r < 26 && cut > 1) cut = $urandom_range(1, cut - 1);
            for (int i = 0; i < cut; i++) add_byte(obj[i], i == cut - 1);
            n_bytes = (n_bytes > cut) ? n_bytes - cut : 0;
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() > 0 || i_in_valid || token_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_depth_limit(input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DEPTH_LIMIT;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        depth_limit_reg = v[4:0];
    endtask

    initial begin
        logic [31:0] limits[7];
        limits = '{32'd1, 32'd16, 32'd3, 32'd0, 32'd31, 32'd8, 32'd2};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (kids[i]) kids[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: scalar extremes, several rejected types, truncation and nesting.
        quiet = 1;
        add_byte(8'h00, 1); add_byte(8'h7F, 1); add_byte(8'hFF, 1); add_byte(8'hE0, 1);
        add_byte(msgtok_pkg::B_NIL, 1); add_byte(msgtok_pkg::B_FALSE, 1);
        add_byte(msgtok_pkg::B_TRUE, 1);
        add_byte(8'hC1, 1);
        add_byte(8'hC7, 0); add_byte(8'h55, 0); add_byte(8'hAA, 1);
        add_byte(8'hCA, 1); add_byte(8'hD8, 1);
        add_byte(8'hD1, 0); add_byte(8'h80, 0); add_byte(8'h00, 1);
        add_byte(8'hCF, 0); repeat (7) add_byte(8'hFF, 0); add_byte(8'hFF, 1);
        add_byte(8'hA1, 0); add_byte(8'h5A, 1);
        add_byte(8'h90, 1); add_byte(8'h80, 1);
        add_byte(8'h81, 0); add_byte(8'h01, 0); add_byte(8'h92, 0); add_byte(8'hC0, 1);
        wait_drained();
        quiet = 0;

        foreach (limits[i]) begin
            write_depth_limit(limits[i]);
            if (i == 2) begin
                quiet = 1;
                hold_req = 1;
            end
            gen_phase(100);
            wait_drained();
            quiet = 0;
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
